// ----- src/owdm_pkg.sv -----
// ============================================================================
// owdm_pkg - shared definitions of the omni wheel drive mixer
// Payload types, angle constants and the first-quadrant cosine series.
// ============================================================================
`default_nettype none

package owdm_pkg;

    localparam int unsigned WHEELS      = 4;
    localparam int unsigned QUARTER_DEG = 90;

    localparam logic [9:0] FULL_TURN    = 10'd360;
    localparam logic [9:0] HALF_TURN    = 10'd180;
    localparam logic [9:0] QUARTER_TURN = 10'd90;
    localparam logic [9:0] THREE_QUARTER_TURN = 10'd270;

    // Wheel order: north-west, north-east, south-west, south-east.
    localparam logic [9:0] WHEEL_OFFSET [WHEELS] = '{10'd315, 10'd45, 10'd225, 10'd135};
    localparam logic [WHEELS-1:0] WHEEL_NEGATE = 4'b1100;

    localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;
    localparam longint unsigned Q30_ONE         = 64'd1 << 30;

    typedef struct packed {
        logic [8:0] heading;
        logic [7:0] drive_speed;
    } owdm_cmd_t;

    typedef struct packed {
        logic [7:0] nw_duty;
        logic       nw_forward;
        logic [7:0] ne_duty;
        logic       ne_forward;
        logic [7:0] sw_duty;
        logic       sw_forward;
        logic [7:0] se_duty;
        logic       se_forward;
    } owdm_result_t;

    // Truncated wheel magnitudes with the sign of their cosine.
    typedef struct packed {
        logic [7:0]              speed;
        logic [WHEELS-1:0][7:0]  mag;
        logic [WHEELS-1:0]       neg;
    } owdm_raw_t;

    // Unsigned quotient by shift and subtract, for elaboration-time tables.
    function automatic longint unsigned owdm_udiv(input longint unsigned n,
                                                  input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Cosine of d degrees (0..90) in Q30 by a nine-term integer series.
    // Used only to build constant tables at elaboration.
    function automatic longint unsigned owdm_cos_q30(input int unsigned d);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned den;
        x    = longint'(d) * RAD_PER_DEG_Q30;
        x2   = (x * x) >> 30;
        term = Q30_ONE;
        sum  = longint'(Q30_ONE);
        for (int k = 1; k <= 8; k++) begin
            den  = longint'((2 * k - 1) * (2 * k));
            term = owdm_udiv((term * x2) >> 30, den);
            if ((k & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(Q30_ONE))
            sum = longint'(Q30_ONE);
        return longint'(sum);
    endfunction

endpackage

`default_nettype wire

// ----- src/owdm_stream_if.sv -----
// ============================================================================
// owdm_stream_if - valid/ready stream channel
// Carries one payload of type T per transfer.
// ============================================================================
`default_nettype none

interface owdm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/owdm_wheel_raw.sv -----
// ============================================================================
// owdm_wheel_raw - angle, cosine and product stages
// Forms trunc0(speed * cos(heading + offset)) for the four wheels in
// three register stages.
// ============================================================================
`default_nettype none

module owdm_wheel_raw #(
    parameter int unsigned COS_FRAC_BITS = 15
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire owdm_pkg::owdm_cmd_t in_data,
    output logic                  out_valid,
    input  wire                   out_ready,
    output owdm_pkg::owdm_raw_t   out_data
);
    import owdm_pkg::*;

    localparam int unsigned CW = COS_FRAC_BITS + 1;
    localparam int unsigned PW = CW + 8;

    typedef logic [CW-1:0] cos_rom_t [0:QUARTER_DEG];

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t        rom;
        longint unsigned q;
        for (int d = 0; d <= int'(QUARTER_DEG); d++) begin
            q = owdm_cos_q30(d);
            q = (q + (64'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS);
            rom[d] = CW'(q);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic rdy1, rdy2, rdy3;

    logic [6:0]    s1_d_reg   [WHEELS];
    logic [6:0]    d_next     [WHEELS];
    logic [WHEELS-1:0] s1_neg_reg, neg_next;
    logic [7:0]    s1_speed_reg;

    logic [CW-1:0] s2_cm_reg  [WHEELS];
    logic [WHEELS-1:0] s2_neg_reg;
    logic [7:0]    s2_speed_reg;

    owdm_raw_t     s3_reg, s3_next;

    assign rdy3     = !s3_valid_reg || out_ready;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: reduce the heading, add each offset and fold into 0..90.
    always_comb
    begin
        logic [9:0] hdg;
        logic [9:0] ang;
        hdg = {1'b0, in_data.heading};
        if (hdg >= FULL_TURN)
            hdg = hdg - FULL_TURN;
        for (int w = 0; w < int'(WHEELS); w++)
        begin
            ang = hdg + WHEEL_OFFSET[w];
            if (ang >= FULL_TURN)
                ang = ang - FULL_TURN;
            if (ang <= QUARTER_TURN)
            begin
                d_next[w]   = ang[6:0];
                neg_next[w] = 1'b0;
            end
            else if (ang <= HALF_TURN)
            begin
                d_next[w]   = 7'(HALF_TURN - ang);
                neg_next[w] = 1'b1;
            end
            else if (ang <= THREE_QUARTER_TURN)
            begin
                d_next[w]   = 7'(ang - HALF_TURN);
                neg_next[w] = 1'b1;
            end
            else
            begin
                d_next[w]   = 7'(FULL_TURN - ang);
                neg_next[w] = 1'b0;
            end
        end
    end

    // Stage 3: scale the cosine magnitude by the speed and drop the fraction.
    always_comb
    begin
        logic [PW-1:0] prod;
        s3_next.speed = s2_speed_reg;
        s3_next.neg   = s2_neg_reg;
        for (int w = 0; w < int'(WHEELS); w++)
        begin
            prod           = PW'(s2_speed_reg) * PW'(s2_cm_reg[w]);
            s3_next.mag[w] = prod[COS_FRAC_BITS +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= in_valid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_d_reg     <= d_next;
            s1_neg_reg   <= neg_next;
            s1_speed_reg <= in_data.drive_speed;
        end
        if (rdy2 && s1_valid_reg)
        begin
            for (int w = 0; w < int'(WHEELS); w++)
                s2_cm_reg[w] <= COS_ROM[s1_d_reg[w]];
            s2_neg_reg   <= s1_neg_reg;
            s2_speed_reg <= s1_speed_reg;
        end
        if (rdy3 && s2_valid_reg)
            s3_reg <= s3_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_reg;

`ifndef ASSERT_OFF
    // The cosine magnitude of wheel 0 never exceeds one.
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_cm_reg[0] <= (CW'(1) << COS_FRAC_BITS)))
        else $error("cosine magnitude above one");
`endif

endmodule

`default_nettype wire

// ----- src/owdm_scale_div.sv -----
// ============================================================================
// owdm_scale_div - largest-magnitude rescale and output stages
// Finds the largest wheel magnitude, divides each wheel's product with the
// speed by it two quotient bits per stage, and forms duty and direction.
// ============================================================================
`default_nettype none

module owdm_scale_div (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire owdm_pkg::owdm_raw_t in_data,
    output logic                  out_valid,
    input  wire                   out_ready,
    output owdm_pkg::owdm_result_t out_data
);
    import owdm_pkg::*;

    localparam int unsigned DIV_STAGES = 4;
    localparam int unsigned LAST = DIV_STAGES + 1;

    logic [0:LAST]     valid_reg;
    logic [0:LAST]     rdy;

    logic [15:0]       rem_reg  [0:DIV_STAGES][WHEELS];
    logic [7:0]        q_reg    [0:DIV_STAGES][WHEELS];
    logic [7:0]        div_reg  [0:DIV_STAGES];
    logic              zero_reg [0:DIV_STAGES];
    logic [WHEELS-1:0] neg_reg  [0:DIV_STAGES];

    logic [15:0]       rem0_next [WHEELS];
    logic [15:0]       rem_next [1:DIV_STAGES][WHEELS];
    logic [7:0]        q_next   [1:DIV_STAGES][WHEELS];
    logic [7:0]        largest_next;

    owdm_result_t      res_reg, res_next;

    always_comb
    begin
        rdy[LAST] = !valid_reg[LAST] || out_ready;
        for (int s = int'(LAST) - 1; s >= 0; s--)
            rdy[s] = !valid_reg[s] || rdy[s+1];
    end
    assign in_ready = rdy[0];

    // Entry stage: largest magnitude by a compare tree, products with speed.
    always_comb
    begin
        logic [7:0] m01;
        logic [7:0] m23;
        m01 = (in_data.mag[0] > in_data.mag[1]) ? in_data.mag[0] : in_data.mag[1];
        m23 = (in_data.mag[2] > in_data.mag[3]) ? in_data.mag[2] : in_data.mag[3];
        largest_next = (m01 > m23) ? m01 : m23;
        for (int w = 0; w < int'(WHEELS); w++)
            rem0_next[w] = 16'(in_data.mag[w]) * 16'(in_data.speed);
    end

    // Division stages: the quotient is below 256, so eight restoring steps
    // from bit 7 down suffice, two of them in each stage.
    always_comb
    begin
        logic [15:0] r;
        logic [7:0]  q;
        logic [15:0] sh;
        for (int s = 1; s <= int'(DIV_STAGES); s++)
        begin
            for (int w = 0; w < int'(WHEELS); w++)
            begin
                r = rem_reg[s-1][w];
                q = q_reg[s-1][w];
                for (int k = 0; k < 2; k++)
                begin
                    sh = 16'(div_reg[s-1]) << (9 - 2 * s - k);
                    if (r >= sh)
                    begin
                        r = r - sh;
                        q[9 - 2 * s - k] = 1'b1;
                    end
                end
                rem_next[s][w] = r;
                q_next[s][w]   = q;
            end
        end
    end

    // Output stage: the south wheels are negated; zero stays forward.
    always_comb
    begin
        logic [7:0]        duty [WHEELS];
        logic [WHEELS-1:0] fwd;
        for (int w = 0; w < int'(WHEELS); w++)
        begin
            if (zero_reg[DIV_STAGES])
            begin
                duty[w] = 8'd0;
                fwd[w]  = 1'b1;
            end
            else
            begin
                duty[w] = q_reg[DIV_STAGES][w];
                fwd[w]  = !((neg_reg[DIV_STAGES][w] ^ WHEEL_NEGATE[w])
                            && (q_reg[DIV_STAGES][w] != 8'd0));
            end
        end
        res_next.nw_duty    = duty[0];
        res_next.nw_forward = fwd[0];
        res_next.ne_duty    = duty[1];
        res_next.ne_forward = fwd[1];
        res_next.sw_duty    = duty[2];
        res_next.sw_forward = fwd[2];
        res_next.se_duty    = duty[3];
        res_next.se_forward = fwd[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                valid_reg[0] <= in_valid;
            for (int s = 1; s <= int'(LAST); s++)
                if (rdy[s])
                    valid_reg[s] <= valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            for (int w = 0; w < int'(WHEELS); w++)
            begin
                rem_reg[0][w] <= rem0_next[w];
                q_reg[0][w]   <= 8'd0;
            end
            div_reg[0]  <= largest_next;
            zero_reg[0] <= (largest_next == 8'd0);
            neg_reg[0]  <= in_data.neg;
        end
        for (int s = 1; s <= int'(DIV_STAGES); s++)
        begin
            if (rdy[s] && valid_reg[s-1])
            begin
                rem_reg[s]  <= rem_next[s];
                q_reg[s]    <= q_next[s];
                div_reg[s]  <= div_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
            end
        end
        if (rdy[LAST] && valid_reg[DIV_STAGES])
            res_reg <= res_next;
    end

    assign out_valid = valid_reg[LAST];
    assign out_data  = res_reg;

`ifndef ASSERT_OFF
    a_nw_zero_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.nw_duty == 8'd0) |-> out_data.nw_forward)
        else $error("north-west zero duty reported in reverse");

    a_sw_zero_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.sw_duty == 8'd0) |-> out_data.sw_forward)
        else $error("south-west zero duty reported in reverse");

    a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.speed == 8'd0) |=> (valid_reg[0] && zero_reg[0]))
        else $error("zero speed not flagged as zero largest magnitude");
`endif

endmodule

`default_nettype wire

// ----- src/omni_wheel_drive_mixer_unit.sv -----
// ============================================================================
// omni_wheel_drive_mixer_unit - four-wheel X omni drive mixer
// Turns a heading and speed into PWM duty and direction for four wheels.
// ============================================================================
// Usage:
//   cmd  (sink)  : one transfer carries heading (degrees, values of 360 and
//                  above wrap) and drive_speed.
//   res  (source): one transfer per command with duty and forward bit of the
//                  north-west, north-east, south-west and south-east wheels.
//   Throughput is one command per cycle while res is ready. The path has nine
//   register stages between a command transfer and its result: three stages
//   form the truncated wheel values (angle fold, cosine table, speed
//   multiply), one finds the largest magnitude, four run the restoring
//   division two quotient bits each, and one forms the outputs.
//   A zero largest magnitude gives all duties zero and all wheels forward.
//   Reset clears only the stage valid bits; no result is pending after it.
//   When the receiver holds ready low the pipeline fills and then drops
//   cmd.ready; a held result stays unchanged until it is taken.
// ============================================================================
`default_nettype none

module omni_wheel_drive_mixer_unit #(
    parameter int unsigned COS_FRAC_BITS = 15
) (
    input  wire clk,
    input  wire rst_n,
    owdm_stream_if.sink   cmd,
    owdm_stream_if.source res
);
    import owdm_pkg::*;

    owdm_raw_t raw_data;
    logic      raw_valid;
    logic      raw_ready;

    owdm_wheel_raw #(
        .COS_FRAC_BITS (COS_FRAC_BITS)
    ) u_raw (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .in_data   (cmd.data),
        .out_valid (raw_valid),
        .out_ready (raw_ready),
        .out_data  (raw_data)
    );

    owdm_scale_div u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (raw_valid),
        .in_ready  (raw_ready),
        .in_data   (raw_data),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (res.data)
    );

endmodule

`default_nettype wire
